// File: src/annuity_rate_secant_solver_core_macros.svh
// ----------------------------------------------------------------------------
// Annuity rate solver assertion macros
// Shared helpers for concurrent checks on clk_i with async low reset.
// ----------------------------------------------------------------------------
`ifndef ANNUITY_RATE_SECANT_SOLVER_CORE_MACROS_SVH
`define ANNUITY_RATE_SECANT_SOLVER_CORE_MACROS_SVH

// same-cycle implication
`define ARSC_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ARSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/arsc_pkg.sv
// ----------------------------------------------------------------------------
// Annuity rate solver package
// Sequencer states, register indexes and unit status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arsc_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 1'd1;

  localparam logic [7:0]  MAX_ITER_RST = 8'd100;
  localparam logic [31:0] TOL_RST      = 32'd429497;
  localparam logic [8:0]  ITER_START   = 9'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATIO,
    ST_CHK,
    ST_RES_BASE,
    ST_POW_TEST,
    ST_POW_MA,
    ST_POW_SHIFT,
    ST_POW_MB,
    ST_RES_D,
    ST_RES_DIV,
    ST_RES_Q1,
    ST_RES_MUL,
    ST_TOL,
    ST_DEN,
    ST_DEN2,
    ST_SEC_MUL,
    ST_SEC_DIV,
    ST_DONE
  } arsc_state_e;

  typedef enum logic [1:0] {
    RET_R,
    RET_R1,
    RET_R0
  } arsc_ret_e;

  typedef struct packed {
    logic done;
    logic ovf;
  } arsc_mul_stat_t;

  typedef struct packed {
    logic done;
  } arsc_div_stat_t;

endpackage

// File: src/arsc_mul.sv
// ----------------------------------------------------------------------------
// Annuity rate solver multiplier
// Saturating signed fixed-point multiply, 16-bit digit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arsc_mul #(
  parameter int W    = 48,
  parameter int FRAC = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [W-1:0]             a_i,
  input  logic [W-1:0]             b_i,
  output logic [W-1:0]             p_o,
  output arsc_pkg::arsc_mul_stat_t stat_o
);
  import arsc_pkg::*;

  localparam int DG  = 16;
  localparam int ND  = (W + DG - 1) / DG;
  localparam int YP  = ND * DG;
  localparam int CW  = $clog2(ND + 1);
  localparam int MQW = 2 * W - FRAC;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic          run_q, fin_q, done_q, neg_q, ovf_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  x_q, p_q;
  logic [YP-1:0] y_q;
  logic [2*W-1:0] acc_q;

  logic [2*W-1:0] xe, de, acc_d;
  logic [MQW-1:0] mq;
  logic           hi_any, above;
  logic [W-1:0]   sat_p;
  logic           sat_ovf;

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign xe    = {{W{1'b0}}, x_q};
  assign de    = {{(2*W-DG){1'b0}}, y_q[YP-1 -: DG]};
  assign acc_d = (acc_q << DG) + xe * de;

  assign mq     = acc_q[2*W-1:FRAC];
  assign hi_any = |mq[MQW-1:W-1];
  assign above  = (|mq[MQW-1:W]) | (mq[W-1] & (|mq[W-2:0]));

  always_comb begin
    sat_ovf = 1'b0;
    if (!neg_q) begin
      if (hi_any) begin
        sat_p   = MAXV;
        sat_ovf = 1'b1;
      end else begin
        sat_p = mq[W-1:0];
      end
    end else begin
      if (hi_any) begin
        sat_p   = MINV;
        sat_ovf = above;
      end else begin
        sat_p = ~mq[W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(ND);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= mag_f(a_i);
      y_q   <= YP'(mag_f(b_i));
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_d;
      y_q   <= y_q << DG;
    end else if (fin_q) begin
      p_q   <= sat_p;
      ovf_q <= sat_ovf;
    end
  end

  assign p_o         = p_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

// File: src/arsc_div.sv
// ----------------------------------------------------------------------------
// Annuity rate solver divider
// Restoring divide of (num << FRAC) by den, one bit per cycle, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arsc_div #(
  parameter int W    = 48,
  parameter int FRAC = 32,
  parameter int NUMW = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NUMW-1:0]          num_i,
  input  logic [NUMW-1:0]          den_i,
  input  logic                     neg_i,
  output logic [W-1:0]             quot_o,
  output arsc_pkg::arsc_div_stat_t stat_o
);
  import arsc_pkg::*;

  localparam int NW = NUMW + FRAC;
  localparam int CW = $clog2(NW + 1);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic            run_q, fin_q, done_q, neg_q, big_q;
  logic [CW-1:0]   cnt_q;
  logic [NW-1:0]   n_q;
  logic [NUMW-1:0] den_q, rem_q;
  logic [W-1:0]    q_q, quot_q;

  logic [NUMW:0]   rem2, diff;
  logic            ge, sat;

  assign rem2 = {rem_q, n_q[NW-1]};
  assign ge   = rem2 >= {1'b0, den_q};
  assign diff = rem2 - {1'b0, den_q};
  assign sat  = big_q | q_q[W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(NW);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {num_i, {FRAC{1'b0}}};
      den_q <= den_i;
      neg_q <= neg_i;
      rem_q <= '0;
      q_q   <= '0;
      big_q <= 1'b0;
    end else if (run_q) begin
      n_q   <= n_q << 1;
      rem_q <= ge ? diff[NUMW-1:0] : rem2[NUMW-1:0];
      q_q   <= {q_q[W-2:0], ge};
      big_q <= big_q | q_q[W-1];
    end else if (fin_q) begin
      if (neg_q) begin
        quot_q <= sat ? MINV : (~q_q + 1'b1);
      end else begin
        quot_q <= sat ? MAXV : q_q;
      end
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.done = done_q;

endmodule

// File: src/annuity_rate_secant_solver_core.sv
// ----------------------------------------------------------------------------
// Annuity rate secant solver core
// Solves PMT/PV = r*(1 + 1/((1+r)^n - 1)) for r in signed fixed point.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis (payment, present value, periods); one result
// item (rate, found, iterations used) leaves on m_axis per input item.
// Registers max_iterations and tolerance are written through cfg_*.
// One item is in work at a time; s_axis_tready is high only while idle.
// Per item: one ratio divide, then per secant iteration three residual
// evaluations and one multiply plus divide. A residual costs about
// 2*bits(n) multiplies and one divide. The work is done on the shared
// divider and multiplier.
// The finished result sits in an output register; the core goes back to
// idle and takes the next item while the receiver stalls, and only waits
// before writing a second result over an untaken one.
// Reset clears the sequencer and output valid and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "annuity_rate_secant_solver_core_macros.svh"

module annuity_rate_secant_solver_core #(
  parameter  int PERIOD_BITS = 10,
  parameter  int FRAC_BITS   = 32,
  parameter  int INT_BITS    = 16,
  localparam int W           = INT_BITS + FRAC_BITS,
  localparam int IN_W        = 64 + PERIOD_BITS,
  localparam int IN_TW       = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = W + 10,
  localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // payment[31:0], present_value[63:32], periods[64+:PERIOD_BITS]
  input  logic [IN_TW-1:0]               s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rate[W-1:0], found[W], iterations_used[W+9:W+1]
  output logic [OUT_TW-1:0]              m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [arsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);
  import arsc_pkg::*;

  localparam int NUMW   = (W > 32) ? W : 32;
  localparam int TOLW   = (FRAC_BITS > 32) ? FRAC_BITS : 32;
  localparam int TOL_SL = (FRAC_BITS > 32) ? FRAC_BITS - 32 : 0;
  localparam int TOL_SR = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;
  localparam int CMPW   = (W > TOLW) ? W : TOLW;
  localparam logic [W-1:0] ONE_C = W'(64'd1 << FRAC_BITS);
  localparam logic [W-1:0] R0_C  = W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [W-1:0] MAXV  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};

  arsc_state_e state_q, state_d;
  arsc_ret_e   ret_q;

  logic [7:0]  max_iter_q;
  logic [31:0] tol_cfg_q;

  logic [PERIOD_BITS-1:0] n_q, nb_q;
  logic [8:0]  iter_q;
  logic [W-1:0] ratio_q, r_q, r0_q, r1_q, x_q, b_q, acc_q, qv_q;
  logic [W-1:0] fr_q, f1_q, f0_q, den_q;
  logic        sat_q, found_q;

  logic        out_valid_q, out_found_q;
  logic [W-1:0] out_rate_q;
  logic [8:0]  out_iter_q;

  logic        in_fire, out_free;
  logic [31:0] in_pmt, in_pv;
  logic [PERIOD_BITS-1:0] in_n;

  logic [W-1:0] add_a, add_b, add_y;
  logic         add_sub;
  logic [W:0]   add_s;

  logic           mul_start;
  logic [W-1:0]   mul_a, mul_b, mul_p;
  arsc_mul_stat_t mul_stat;

  logic            div_start, div_neg;
  logic [NUMW-1:0] div_num, div_den;
  logic [W-1:0]    div_q;
  arsc_div_stat_t  div_stat;

  logic [TOLW-1:0] tol;
  logic            tol_ok;

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_pmt  = s_axis_tdata[31:0];
  assign in_pv   = s_axis_tdata[63:32];
  assign in_n    = s_axis_tdata[64 +: PERIOD_BITS];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || m_axis_tready;

  assign tol    = (TOLW'(tol_cfg_q) << TOL_SL) >> TOL_SR;
  assign tol_ok = CMPW'(mag_f(fr_q)) <= CMPW'(tol);

  // shared saturating adder
  assign add_s = add_sub ? ({add_a[W-1], add_a} - {add_b[W-1], add_b})
                         : ({add_a[W-1], add_a} + {add_b[W-1], add_b});
  assign add_y = (add_s[W] != add_s[W-1]) ? (add_s[W] ? MINV : MAXV) : add_s[W-1:0];

  arsc_mul #(.W(W), .FRAC(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .p_o     (mul_p),
    .stat_o  (mul_stat)
  );

  arsc_div #(.W(W), .FRAC(FRAC_BITS), .NUMW(NUMW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .neg_i   (div_neg),
    .quot_o  (div_q),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_fire) state_d = (in_pv == '0) ? ST_DONE : ST_RATIO;
      ST_RATIO:     if (div_stat.done) state_d = ST_CHK;
      ST_CHK:       state_d = (iter_q > {1'b0, max_iter_q}) ? ST_DONE : ST_RES_BASE;
      ST_RES_BASE:  state_d = ST_POW_TEST;
      ST_POW_TEST: begin
        if (nb_q == '0) state_d = ST_RES_D;
        else if (nb_q[0]) state_d = ST_POW_MA;
        else state_d = ST_POW_SHIFT;
      end
      ST_POW_MA:    if (mul_stat.done) state_d = ST_POW_SHIFT;
      ST_POW_SHIFT: state_d = ((nb_q >> 1) != '0) ? ST_POW_MB : ST_RES_D;
      ST_POW_MB:    if (mul_stat.done) state_d = ST_POW_TEST;
      ST_RES_D:     state_d = (sat_q || add_y == '0) ? ST_RES_Q1 : ST_RES_DIV;
      ST_RES_DIV:   if (div_stat.done) state_d = ST_RES_Q1;
      ST_RES_Q1:    state_d = ST_RES_MUL;
      ST_RES_MUL: begin
        if (mul_stat.done) begin
          case (ret_q)
            RET_R:   state_d = ST_TOL;
            RET_R1:  state_d = ST_RES_BASE;
            default: state_d = ST_DEN;
          endcase
        end
      end
      ST_TOL:       state_d = tol_ok ? ST_DONE : ST_RES_BASE;
      ST_DEN:       state_d = ST_DEN2;
      ST_DEN2:      state_d = (den_q == '0) ? ST_DONE : ST_SEC_MUL;
      ST_SEC_MUL:   if (mul_stat.done) state_d = ST_SEC_DIV;
      ST_SEC_DIV:   if (div_stat.done) state_d = ST_CHK;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    add_a     = ONE_C;
    add_b     = '0;
    add_sub   = 1'b0;
    mul_start = 1'b0;
    mul_a     = acc_q;
    mul_b     = b_q;
    div_start = 1'b0;
    div_num   = NUMW'(in_pmt);
    div_den   = NUMW'(in_pv);
    div_neg   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        div_start = in_fire && (in_pv != '0);
      end
      ST_RES_BASE: begin
        add_b = x_q;
      end
      ST_POW_TEST: begin
        mul_start = (nb_q != '0) && nb_q[0];
      end
      ST_POW_SHIFT: begin
        mul_start = (nb_q >> 1) != '0;
        mul_a     = b_q;
      end
      ST_RES_D: begin
        add_a     = acc_q;
        add_b     = ONE_C;
        add_sub   = 1'b1;
        div_start = !sat_q && (add_y != '0);
        div_num   = NUMW'(ONE_C);
        div_den   = NUMW'(mag_f(add_y));
        div_neg   = add_y[W-1];
      end
      ST_RES_Q1: begin
        add_b     = qv_q;
        mul_start = 1'b1;
        mul_a     = x_q;
        mul_b     = add_y;
      end
      ST_RES_MUL: begin
        add_a   = ratio_q;
        add_b   = mul_p;
        add_sub = 1'b1;
      end
      ST_DEN: begin
        add_a   = f1_q;
        add_b   = f0_q;
        add_sub = 1'b1;
      end
      ST_DEN2: begin
        add_a     = r1_q;
        add_b     = r0_q;
        add_sub   = 1'b1;
        mul_start = den_q != '0;
        mul_a     = f1_q;
        mul_b     = add_y;
      end
      ST_SEC_MUL: begin
        div_start = mul_stat.done;
        div_num   = NUMW'(mag_f(mul_p));
        div_den   = NUMW'(mag_f(den_q));
        div_neg   = mul_p[W-1] ^ den_q[W-1];
      end
      ST_SEC_DIV: begin
        add_a   = r1_q;
        add_b   = div_q;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      max_iter_q <= MAX_ITER_RST;
      tol_cfg_q  <= TOL_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_ITER: max_iter_q <= cfg_data_i[7:0];
          CFG_TOL:      tol_cfg_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        n_q     <= in_n;
        iter_q  <= ITER_START;
        found_q <= 1'b0;
      end
      ST_RATIO: begin
        ratio_q <= div_q;
        r0_q    <= R0_C;
        r1_q    <= ONE_C;
        r_q     <= R0_C;
      end
      ST_CHK: begin
        x_q   <= r_q;
        ret_q <= RET_R;
      end
      ST_RES_BASE: begin
        b_q   <= add_y;
        acc_q <= ONE_C;
        nb_q  <= n_q;
        sat_q <= 1'b0;
      end
      ST_POW_MA: begin
        if (mul_stat.done) begin
          acc_q <= mul_p;
          sat_q <= sat_q | mul_stat.ovf;
        end
      end
      ST_POW_SHIFT: nb_q <= nb_q >> 1;
      ST_POW_MB: begin
        if (mul_stat.done) begin
          b_q   <= mul_p;
          sat_q <= sat_q | mul_stat.ovf;
        end
      end
      ST_RES_D: begin
        if (sat_q) qv_q <= '0;
        else if (add_y == '0) qv_q <= MAXV;
      end
      ST_RES_DIV: if (div_stat.done) qv_q <= div_q;
      ST_RES_MUL: begin
        if (mul_stat.done) begin
          case (ret_q)
            RET_R:  fr_q <= add_y;
            RET_R1: begin
              f1_q  <= add_y;
              x_q   <= r0_q;
              ret_q <= RET_R0;
            end
            default: f0_q <= add_y;
          endcase
        end
      end
      ST_TOL: begin
        found_q <= tol_ok;
        x_q     <= r1_q;
        ret_q   <= RET_R1;
      end
      ST_DEN: den_q <= add_y;
      ST_SEC_DIV: begin
        if (div_stat.done) begin
          r_q    <= add_y;
          r0_q   <= r1_q;
          r1_q   <= add_y;
          iter_q <= iter_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_rate_q  <= found_q ? r_q : '0;
      out_found_q <= found_q;
      out_iter_q  <= iter_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_iter_q, out_found_q, out_rate_q});

  `ARSC_ASSERT_IMPLY(a_rate_zero, m_axis_tvalid && !out_found_q, out_rate_q == '0,
    "rate not zero on a not-found result")
  `ARSC_ASSERT_IMPLY(a_iter_min, m_axis_tvalid, out_iter_q >= ITER_START,
    "iteration count below start value")
  `ARSC_ASSERT_IMPLY(a_div_owner, div_stat.done,
    state_q == ST_RATIO || state_q == ST_RES_DIV || state_q == ST_SEC_DIV,
    "divider finished with no consumer waiting")
  `ARSC_ASSERT_IMPLY(a_mul_owner, mul_stat.done,
    state_q == ST_POW_MA || state_q == ST_POW_MB || state_q == ST_RES_MUL ||
    state_q == ST_SEC_MUL, "multiplier finished with no consumer waiting")
  `ARSC_ASSERT_NEXT(a_iter_step, state_q == ST_SEC_DIV && div_stat.done,
    iter_q == $past(iter_q) + 9'd1, "iteration counter did not advance")

endmodule

// File: dv/tb_annuity_rate_secant_solver_core.sv
// ----------------------------------------------------------------------------
// Annuity rate solver core testbench
// Sends directed and random loan items (payment, present value, periods) over
// the input stream. A fixed-point secant predictor works out rate, found flag
// and iteration count for each item. Results are checked in order under
// random idling on both sides and across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_annuity_rate_secant_solver_core;
  import arsc_pkg::*;

  localparam longint MAXV = (64'sd1 <<< 47) - 1;
  localparam longint MINV = -MAXV - 1;
  localparam longint ONE = 64'sd1 <<< 32;
  localparam longint SEED_LO = 64'sd429497;
  localparam int WATCHDOG_LIMIT = 2000000;

  typedef struct {
    logic [47:0] rate;
    logic        found;
    logic [8:0]  iters;
  } solve_t;

  typedef struct {
    logic [31:0] pmt;
    logic [31:0] pv;
    logic [9:0]  n;
    bit          typed;
    solve_t      res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_MAX_ITER;
  logic [31:0] cfg_data_i = '0;

  logic [7:0]  max_iter_q = MAX_ITER_RST;
  logic [31:0] tol_q = TOL_RST;

  solve_t      pending_q[$];
  solve_t      typed_q[$];
  bit          typed_flag_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          found_seen = 0;
  int          sent = 0;
  int          snd_idle = 37;
  int          rcv_idle = 71;
  int          idle_cnt = 0;

  annuity_rate_secant_solver_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic logic [127:0] mag(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint sat_mag(bit neg, logic [127:0] m, inout bit ovf);
    if (!neg) begin
      if (m > 128'(MAXV)) begin
        ovf = 1'b1;
        return MAXV;
      end
      return longint'(m);
    end
    if (m > 128'(MAXV)) begin
      if (m > 128'(MAXV) + 1) ovf = 1'b1;
      return MINV;
    end
    return -longint'(m);
  endfunction

  function automatic longint clamp(longint v);
    return v > MAXV ? MAXV : (v < MINV ? MINV : v);
  endfunction

  function automatic longint fmul(longint a, longint b, inout bit ovf);
    return sat_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> 32, ovf);
  endfunction

  function automatic logic [127:0] qdiv(logic [127:0] num, logic [127:0] den);
    return (num << 32) / den;
  endfunction

  function automatic longint fdiv(longint a, longint b);
    bit dummy;
    dummy = 1'b0;
    if (b == 0) return a < 0 ? MINV : MAXV;
    return sat_mag((a < 0) != (b < 0), qdiv(mag(a), mag(b)), dummy);
  endfunction

  function automatic longint resid(longint r, longint ratio, logic [9:0] n);
    bit sat, ovf;
    longint acc, b, d, q;
    logic [9:0] k;
    sat = 1'b0;
    ovf = 1'b0;
    acc = ONE;
    b = clamp(ONE + r);
    k = n;
    while (k != 0) begin
      if (k[0]) acc = fmul(acc, b, sat);
      k = k >> 1;
      if (k != 0) b = fmul(b, b, sat);
    end
    if (sat) q = 0;
    else begin
      d = clamp(acc - ONE);
      q = (d == 0) ? MAXV : fdiv(ONE, d);
    end
    return clamp(ratio - fmul(r, clamp(ONE + q), ovf));
  endfunction

  function automatic solve_t solve_rate(logic [31:0] pmt, logic [31:0] pv, logic [9:0] n);
    solve_t s;
    bit ovf, stuck;
    int iter;
    longint ratio, r0, r1, r, f0, f1, den;
    ovf = 1'b0;
    stuck = 1'b0;
    iter = 2;
    r = 0;
    s.found = 1'b0;
    if (pv != 0) begin
      ratio = sat_mag(1'b0, qdiv(128'(pmt), 128'(pv)), ovf);
      r0 = SEED_LO;
      r1 = ONE;
      r = r0;
      while (iter <= int'(max_iter_q) && mag(resid(r, ratio, n)) > 128'(tol_q)) begin
        f1 = resid(r1, ratio, n);
        f0 = resid(r0, ratio, n);
        den = clamp(f1 - f0);
        if (den == 0) begin
          stuck = 1'b1;
          break;
        end
        r = clamp(r1 - fdiv(fmul(f1, clamp(r1 - r0), ovf), den));
        r0 = r1;
        r1 = r;
        iter++;
      end
      s.found = !stuck && iter <= int'(max_iter_q);
    end
    if (!s.found) r = 0;
    s.rate = r[47:0];
    s.iters = iter[8:0];
    return s;
  endfunction

  // ---------------- checking ----------------
  task automatic report(string what, longint exp_v, longint got_v);
    $display("MISMATCH result %0d %s: expected 0x%0h got 0x%0h",
             results_seen, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk_i) begin
    solve_t e;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          report("unexpected item", 0, longint'(m_axis_tdata));
        end else begin
          e = pending_q.pop_front();
          if (m_axis_tdata[47:0] !== e.rate) report("rate", e.rate, m_axis_tdata[47:0]);
          if (m_axis_tdata[48] !== e.found) report("found", e.found, m_axis_tdata[48]);
          if (m_axis_tdata[57:49] !== e.iters) report("iterations", e.iters, m_axis_tdata[57:49]);
          if (m_axis_tdata[48] === 1'b1) found_seen++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_item(logic [31:0] pmt, logic [31:0] pv, logic [9:0] n,
                           bit typed, solve_t res);
    solve_t p;
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, n, pv, pmt};
    do @(posedge clk_i); while (!s_axis_tready);
    p = solve_rate(pmt, pv, n);
    if (typed && (p.rate !== res.rate || p.found !== res.found || p.iters !== res.iters))
      $display("Note: predictor disagrees with table row %0d", sent);
    pending_q.push_back(typed ? res : p);
    sent++;
  endtask

  task automatic drain_and_write(logic [7:0] mi, logic [31:0] tol);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MAX_ITER;
    cfg_data_i <= {24'd0, mi};
    @(posedge clk_i);
    cfg_idx_i <= CFG_TOL;
    cfg_data_i <= tol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_iter_q = mi;
    tol_q = tol;
  endtask

  task automatic random_item(bit noisy);
    real r, amt;
    logic [31:0] pmt, pv;
    logic [9:0] n;
    solve_t none;
    none = '{default: '0};
    if (noisy && $urandom_range(99) < 15) begin
      pmt = $urandom;
      pv = $urandom;
      n = 10'($urandom_range(1023));
    end else begin
      r = $urandom_range(1, 3000) / 100000.0;
      n = ($urandom_range(9) == 0) ? 10'($urandom_range(1, 1023)) : 10'($urandom_range(1, 400));
      pv = $urandom_range(1000, 32'hFFFF_FFFF);
      amt = pv * r / (1.0 - (1.0 + r) ** (-1.0 * n));
      pmt = (amt > 4294967295.0) ? 32'hFFFF_FFFF : 32'(longint'(amt));
    end
    send_item(pmt, pv, n, 1'b0, none);
  endtask

  initial begin
    row_t rows[$];
    solve_t none, zero_pv;
    none = '{default: '0};
    zero_pv = '{rate: 48'd0, found: 1'b0, iters: ITER_START};
    rows = '{
      '{32'd0,          32'd0,          10'd360,  1'b1, zero_pv},
      '{32'hFFFF_FFFF,  32'd0,          10'd1023, 1'b1, zero_pv},
      '{32'd0,          32'd0,          10'd0,    1'b1, zero_pv},
      '{32'd1000,       32'd100000,     10'd360,  1'b0, none},
      '{32'd600,        32'd100000,     10'd360,  1'b0, none},
      '{32'd110000,     32'd100000,     10'd1,    1'b0, none},
      '{32'd50,         32'd100000,     10'd1023, 1'b0, none},
      '{32'd0,          32'd100000,     10'd12,   1'b0, none},
      '{32'd1,          32'hFFFF_FFFF,  10'd1023, 1'b0, none},
      '{32'd8885,       32'd100000,     10'd12,   1'b0, none},
      '{32'd100000,     32'd100000,     10'd0,    1'b0, none},
      '{32'hFFFF_FFFF,  32'd1,          10'd5,    1'b0, none},
      '{32'h8000_0000,  32'hFFFF_FFFF,  10'd512,  1'b0, none},
      '{32'd2000,       32'd50000,      10'd36,   1'b0, none}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].pmt, rows[i].pv, rows[i].n, rows[i].typed, rows[i].res);

    // wide-open tolerance, longest limit
    drain_and_write(8'd255, 32'hFFFF_FFFF);
    repeat (34) random_item(1'b0);

    snd_idle = 71;
    rcv_idle = 37;
    drain_and_write(8'd2, 32'd0);
    repeat (34) random_item(1'b1);

    snd_idle = 0;
    rcv_idle = 0;
    drain_and_write(8'd60, 32'd20000);
    repeat (34) random_item(1'b1);

    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d loan items over four register settings, %0d results, %0d converged.",
             sent, results_seen, found_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
